[design/fahp_pkg.sv]
`default_nettype none

package fahp_pkg;

   localparam int unsigned SecW   = 4;
   localparam int unsigned CountW = 16;
   localparam int unsigned TotalW = 20;
   localparam int unsigned StampW = 64;
   localparam int unsigned LenW   = 16;
   localparam int unsigned NumLen = 4;

   // section codes, also the parser phase
   localparam logic [SecW-1:0] SEC_ID      = 4'd0;
   localparam logic [SecW-1:0] SEC_STAMP   = 4'd1;
   localparam logic [SecW-1:0] SEC_CRTLEN  = 4'd2;
   localparam logic [SecW-1:0] SEC_CRT     = 4'd3;
   localparam logic [SecW-1:0] SEC_EPHLEN  = 4'd4;
   localparam logic [SecW-1:0] SEC_EPH     = 4'd5;
   localparam logic [SecW-1:0] SEC_DATALEN = 4'd6;
   localparam logic [SecW-1:0] SEC_DATA    = 4'd7;
   localparam logic [SecW-1:0] SEC_SIGLEN  = 4'd8;
   localparam logic [SecW-1:0] SEC_SIG     = 4'd9;
   localparam logic [SecW-1:0] SEC_EXCESS  = 4'd10;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_SHORT    = 2'd1;
   localparam logic [1:0] ST_TRUNC    = 2'd2;
   localparam logic [1:0] ST_TRAILING = 2'd3;

   localparam logic [TotalW-1:0] TotalMax = '1;

   typedef logic [LenW-1:0] len_array_type [NumLen];

   typedef struct packed {
      logic [SecW-1:0]          phase;
      logic [CountW-1:0]        section_count;
      logic [TotalW-1:0]        total_count;
      logic [StampW-1:0]        stamp;
      logic [NumLen-1:0][LenW-1:0] lens;
   } fahp_state_type;

   typedef struct packed {
      logic [7:0]               byte_out;
      logic [SecW-1:0]          section;
      logic                     is_done;
      logic [1:0]               status;
      logic [StampW-1:0]        timestamp;
      logic [NumLen-1:0][LenW-1:0] lens;
   } fahp_rsp_type;

   // length register belonging to a length phase or to the section it sizes
   function automatic logic [1:0] len_index(input logic [SecW-1:0] ph);
      return ph[2:1] - 2'd1;
   endfunction

   function automatic logic is_len_phase(input logic [SecW-1:0] ph);
      return (ph == SEC_CRTLEN) || (ph == SEC_EPHLEN) || (ph == SEC_DATALEN) ||
             (ph == SEC_SIGLEN);
   endfunction

   function automatic logic is_body_phase(input logic [SecW-1:0] ph);
      return (ph == SEC_CRT) || (ph == SEC_EPH) || (ph == SEC_DATA) || (ph == SEC_SIG);
   endfunction

endpackage

`default_nettype wire

[design/fahp_step.sv]
`default_nettype none

module fahp_step import fahp_pkg::*; #(
   parameter int unsigned ID_BYTES  = 16,
   parameter int unsigned MIN_BYTES = 32
) (
   input  fahp_state_type state_cur,
   input  logic [7:0]     byte_in,
   input  logic           last_byte,
   output fahp_state_type state_nxt,
   output fahp_rsp_type   rsp
);

   fahp_state_type    upd;
   logic [CountW-1:0] sc_inc;
   logic [CountW-1:0] size;
   logic [SecW-1:0]   ph_adv;
   logic [1:0]        status;

   always_comb begin
      upd = state_cur;
      sc_inc = state_cur.section_count + CountW'(1);
      ph_adv = state_cur.phase + SecW'(1);

      if (state_cur.total_count != TotalMax) begin
         upd.total_count = state_cur.total_count + TotalW'(1);
      end

      unique case (state_cur.phase)
         SEC_ID:    size = CountW'(ID_BYTES);
         SEC_STAMP: size = CountW'(8);
         SEC_CRT, SEC_EPH, SEC_DATA, SEC_SIG:
                    size = state_cur.lens[len_index(state_cur.phase)];
         default:   size = CountW'(2);
      endcase

      if (state_cur.phase < SEC_EXCESS) begin
         if (state_cur.phase == SEC_STAMP) begin
            upd.stamp = {state_cur.stamp[StampW-9:0], byte_in};
         end else if (is_len_phase(state_cur.phase)) begin
            upd.lens[len_index(state_cur.phase)] =
               {state_cur.lens[len_index(state_cur.phase)][7:0], byte_in};
         end
         if (sc_inc >= size) begin
            // empty sections are skipped straight to the next length field, or to excess after the signature
            if (is_body_phase(ph_adv) && upd.lens[len_index(ph_adv)] == '0) begin
               upd.phase = ph_adv + SecW'(1);
            end else begin
               upd.phase = ph_adv;
            end
            upd.section_count = '0;
         end else begin
            upd.section_count = sc_inc;
         end
      end

      priority if (upd.total_count < TotalW'(MIN_BYTES)) begin
         status = ST_SHORT;
      end else if (upd.phase != SEC_EXCESS) begin
         status = ST_TRUNC;
      end else if (state_cur.phase == SEC_EXCESS) begin
         status = ST_TRAILING;
      end else begin
         status = ST_OK;
      end

      rsp = '0;
      rsp.byte_out = byte_in;
      rsp.section  = state_cur.phase;
      if (last_byte) begin
         rsp.is_done = 1'b1;
         rsp.status  = status;
         if (status == ST_OK) begin
            rsp.timestamp = upd.stamp;
            rsp.lens      = upd.lens;
         end
      end

      state_nxt = last_byte ? fahp_state_type'('0) : upd;
   end

endmodule

`default_nettype wire

[design/flow_alloc_header_parser_top.sv]
// channel  | direction | handshake              | payload
// req_     | in        | req_valid / req_ready  | byte_in, last_byte
// rsp_     | out       | rsp_valid / rsp_ready  | byte_out, section, is_done, status,
//          |           |                        | timestamp_out, cert/ephkey/data/sig_len
//
// One word in, one word out, one per cycle unless rsp_ready stalls; the result of
// a word is held in the single result register behind the parser step logic.
// Reset is synchronous and returns the parser to the start of a header.
// A word is taken whenever the result register is empty or being drained, so
// a stall on rsp_ready holds off req_ready only while the result is stuck.
// After the final byte the parser state is cleared for the next header.
`default_nettype none

module flow_alloc_header_parser_top import fahp_pkg::*; #(
   parameter int unsigned ID_BYTES  = 16,
   parameter int unsigned MIN_BYTES = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_byte_in,
   input  wire logic         req_last_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [7:0]        rsp_byte_out,
   output logic [SecW-1:0]   rsp_section,
   output logic              rsp_is_done,
   output logic [1:0]        rsp_status,
   output logic [StampW-1:0] rsp_timestamp_out,
   output logic [LenW-1:0]   rsp_cert_len,
   output logic [LenW-1:0]   rsp_ephkey_len,
   output logic [LenW-1:0]   rsp_data_len,
   output logic [LenW-1:0]   rsp_sig_len
);

   fahp_state_type state_ff, state_in;
   fahp_rsp_type   rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_fire;

   fahp_step #(
      .ID_BYTES  (ID_BYTES),
      .MIN_BYTES (MIN_BYTES)
   ) u_step (
      .state_cur (state_ff),
      .byte_in   (req_byte_in),
      .last_byte (req_last_byte),
      .state_nxt (state_in),
      .rsp       (rsp_in)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_out      = rsp_ff.byte_out;
   assign rsp_section       = rsp_ff.section;
   assign rsp_is_done       = rsp_ff.is_done;
   assign rsp_status        = rsp_ff.status;
   assign rsp_timestamp_out = rsp_ff.timestamp;
   assign rsp_cert_len      = rsp_ff.lens[0];
   assign rsp_ephkey_len    = rsp_ff.lens[1];
   assign rsp_data_len      = rsp_ff.lens[2];
   assign rsp_sig_len       = rsp_ff.lens[3];

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_last_byte |=> state_ff.phase == SEC_ID && state_ff.total_count == '0)
      else $error("parser state not cleared after final byte");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase <= SEC_EXCESS)
      else $error("phase beyond excess section");

   a_id_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == SEC_ID |-> state_ff.total_count == TotalW'(state_ff.section_count))
      else $error("identifier byte count disagrees with header count");

   a_fail_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK |-> rsp_ff.timestamp == '0 && rsp_ff.lens == '0)
      else $error("fields reported on a failed header");

   a_mid_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.is_done |-> rsp_ff.status == ST_OK)
      else $error("status set on a non-final word");

endmodule

`default_nettype wire

[tb/flow_alloc_header_parser_top_test.sv]
`timescale 1ns / 100ps

module flow_alloc_header_parser_top_test import fahp_pkg::*;;

   localparam int unsigned ID_BYTES  = 16;
   localparam int unsigned MIN_BYTES = 32;
   localparam int RANDOM_WORDS = 1550;
   localparam int QUIET_TAIL   = 150;
   localparam int HOLD_CYCLES  = 100;
   localparam int IDLE_LIMIT   = 2000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } hdr_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_byte_in = 8'd0;
   logic              req_last_byte = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [7:0]        rsp_byte_out;
   logic [SecW-1:0]   rsp_section;
   logic              rsp_is_done;
   logic [1:0]        rsp_status;
   logic [StampW-1:0] rsp_timestamp_out;
   logic [LenW-1:0]   rsp_cert_len;
   logic [LenW-1:0]   rsp_ephkey_len;
   logic [LenW-1:0]   rsp_data_len;
   logic [LenW-1:0]   rsp_sig_len;

   flow_alloc_header_parser_top #(
      .ID_BYTES (ID_BYTES),
      .MIN_BYTES(MIN_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_in      (req_byte_in),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_section      (rsp_section),
      .rsp_is_done      (rsp_is_done),
      .rsp_status       (rsp_status),
      .rsp_timestamp_out(rsp_timestamp_out),
      .rsp_cert_len     (rsp_cert_len),
      .rsp_ephkey_len   (rsp_ephkey_len),
      .rsp_data_len     (rsp_data_len),
      .rsp_sig_len      (rsp_sig_len)
   );

   hdr_word_type pending_words[$];
   fahp_rsp_type expected_rsps[$];
   hdr_word_type next_word;
   fahp_rsp_type parsed_rsp;
   fahp_rsp_type head_rsp;

   int errors = 0;
   int words_in = 0;
   int words_out = 0;
   int words_total = 0;
   int headers_queued = 0;
   int status_seen[4] = '{0, 0, 0, 0};
   int send_gap = 0;
   int recv_gap = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int idle_cycles = 0;

   // parser state as the block should hold it
   logic [SecW-1:0]   hp_phase;
   logic [CountW-1:0] hp_count;
   logic [TotalW-1:0] hp_total;
   logic [StampW-1:0] hp_stamp;
   logic [LenW-1:0]   hp_len[NumLen];

   function automatic logic [CountW-1:0] sect_bytes(input logic [SecW-1:0] ph);
      case (ph)
         SEC_ID:    return CountW'(ID_BYTES);
         SEC_STAMP: return 16'd8;
         SEC_CRT:   return hp_len[0];
         SEC_EPH:   return hp_len[1];
         SEC_DATA:  return hp_len[2];
         SEC_SIG:   return hp_len[3];
         default:   return 16'd2;
      endcase
   endfunction

   task automatic clear_parse();
      hp_phase = SEC_ID;
      hp_count = '0;
      hp_total = '0;
      hp_stamp = '0;
      for (int i = 0; i < NumLen; i++) hp_len[i] = '0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic last, output fahp_rsp_type r);
      logic [SecW-1:0] tag;
      logic [1:0]      k;
      tag = hp_phase;
      r = '0;
      if (hp_total != TotalMax) hp_total = hp_total + TotalW'(1);
      if (hp_phase < SEC_EXCESS) begin
         case (hp_phase)
            SEC_STAMP: hp_stamp = {hp_stamp[StampW-9:0], b};
            SEC_CRTLEN, SEC_EPHLEN, SEC_DATALEN, SEC_SIGLEN: begin
               k = 2'((hp_phase - SEC_CRTLEN) >> 1);
               hp_len[k] = {hp_len[k][7:0], b};
            end
            default: ;
         endcase
         hp_count = hp_count + CountW'(1);
         if (hp_count >= sect_bytes(hp_phase)) begin
            hp_phase = hp_phase + SecW'(1);
            // an empty body is skipped straight to the next length, or to excess after the signature
            if ((hp_phase == SEC_CRT || hp_phase == SEC_EPH || hp_phase == SEC_DATA ||
                 hp_phase == SEC_SIG) && sect_bytes(hp_phase) == '0)
               hp_phase = hp_phase + SecW'(1);
            hp_count = '0;
         end
      end
      r.byte_out = b;
      r.section  = tag;
      if (last) begin
         r.is_done = 1'b1;
         if (hp_total < MIN_BYTES)
            r.status = ST_SHORT;
         else if (hp_phase != SEC_EXCESS)
            r.status = ST_TRUNC;
         else if (tag == SEC_EXCESS)
            r.status = ST_TRAILING;
         else
            r.status = ST_OK;
         if (r.status == ST_OK) begin
            r.timestamp = hp_stamp;
            for (int i = 0; i < NumLen; i++) r.lens[i] = hp_len[i];
         end
         clear_parse();
      end
   endtask

   // fill < 0 gives random bytes; cut > 0 ends the header at that many bytes when it is shorter than the header
   task automatic queue_header(input int crt, input int eph, input int dat, input int sig,
                               input int extra, input int cut, input int fill);
      logic [7:0]     hb[$];
      logic [LenW-1:0] lv[NumLen];
      int n;
      lv[0] = LenW'(crt);
      lv[1] = LenW'(eph);
      lv[2] = LenW'(dat);
      lv[3] = LenW'(sig);
      repeat (ID_BYTES + 8) hb.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
      for (int s = 0; s < NumLen; s++) begin
         hb.push_back(lv[s][15:8]);
         hb.push_back(lv[s][7:0]);
         for (int j = 0; j < lv[s] && hb.size() < 4096; j++)
            hb.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
      end
      repeat (extra) hb.push_back(8'($urandom));
      n = (cut > 0 && cut < hb.size()) ? cut : hb.size();
      for (int i = 0; i < n; i++) pending_words.push_back('{hb[i], i == n - 1});
      headers_queued++;
   endtask

   function automatic int rand_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return 0;
      if (r < 90) return $urandom_range(1, 12);
      if (r < 98) return $urandom_range(13, 60);
      return $urandom_range(200, 400);
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   function automatic bit idling_on();
      return ((words_in / 200) % 3) != 2;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_byte_in, req_last_byte, parsed_rsp);
            expected_rsps.push_back(parsed_rsp);
            words_in++;
         end
         if (req_valid && !req_ready) begin
            // word held until taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > QUIET_TAIL && idling_on() &&
                      $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 2);
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            next_word = pending_words.pop_front();
            req_valid     <= 1'b1;
            req_byte_in   <= next_word.data;
            req_last_byte <= next_word.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_out++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected word, byte %0h section %0d", $time,
                        rsp_byte_out, rsp_section);
               errors++;
            end else begin
               head_rsp = expected_rsps.pop_front();
               check_field("byte_out", 64'(head_rsp.byte_out), 64'(rsp_byte_out));
               check_field("section", 64'(head_rsp.section), 64'(rsp_section));
               check_field("is_done", 64'(head_rsp.is_done), 64'(rsp_is_done));
               check_field("status", 64'(head_rsp.status), 64'(rsp_status));
               check_field("timestamp_out", head_rsp.timestamp, rsp_timestamp_out);
               check_field("cert_len", 64'(head_rsp.lens[0]), 64'(rsp_cert_len));
               check_field("ephkey_len", 64'(head_rsp.lens[1]), 64'(rsp_ephkey_len));
               check_field("data_len", 64'(head_rsp.lens[2]), 64'(rsp_data_len));
               check_field("sig_len", 64'(head_rsp.lens[3]), 64'(rsp_sig_len));
               if (head_rsp.is_done) status_seen[head_rsp.status]++;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && words_in >= 300) begin
            // long back-pressure so the input side stalls
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (words_out + QUIET_TAIL < words_total && idling_on() &&
                      $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress, %0d words still expected", $time, expected_rsps.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int kind;
      clear_parse();

      // directed: single-byte header, then a minimal header with all-ones identifier and stamp and empty sections
      pending_words.push_back('{8'h00, 1'b1});
      headers_queued++;
      queue_header(0, 0, 0, 0, 0, 0, 8'hFF);

      while (pending_words.size() < RANDOM_WORDS + 33) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            queue_header(rand_len(), rand_len(), rand_len(), rand_len(), 0, 0, -1);
         end else if (kind < 70) begin
            queue_header(rand_len(), rand_len(), rand_len(), rand_len(),
                         $urandom_range(1, 4), 0, -1);
         end else if (kind < 82) begin
            // cut at or past the minimum size, inside some section unless the header is shorter
            queue_header($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 8),
                         $urandom_range(1, 8), 0, $urandom_range(MIN_BYTES, 60), -1);
         end else if (kind < 92) begin
            queue_header(rand_len(), rand_len(), rand_len(), rand_len(), 0,
                         $urandom_range(1, MIN_BYTES - 1), -1);
         end else begin
            // random 16-bit lengths, cut well before the bodies end
            queue_header($urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 65535), 0,
                         $urandom_range(26, 60), -1);
         end
      end
      words_total = pending_words.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);

      $display("Parsed %0d words over %0d headers, with random gaps and one long stall.",
               words_out, headers_queued);
      $display("Final status: %0d ok, %0d short, %0d truncated, %0d with trailing bytes.",
               status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_TRUNC],
               status_seen[ST_TRAILING]);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
